@@ hdl/quaternion_multiply_rotate_unit_macros.svh @@
// assertion helpers for the quaternion unit, clocked on clk, held off in reset
`ifndef QUATERNION_MULTIPLY_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_MULTIPLY_ROTATE_UNIT_MACROS_SVH

// same-cycle implication
`define QMRU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QMRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/qmru_pkg.sv @@
package qmru_pkg;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_ROT = 1'b1
  } qmru_op_t;

  localparam int NUM_COMP = 4;
  localparam int NUM_PROD = NUM_COMP * NUM_COMP;

endpackage

@@ hdl/quaternion_multiply_rotate_unit.sv @@
// channel | ports                                  | direction
// --------+----------------------------------------+----------
// in      | in_valid/in_ready, in_opcode, in_a_*,  | input
//         | in_b_*                                 |
// out     | out_valid/out_ready, out_r_*,          | output
//         | out_saturated                          |
// four register stages: multiply, sum/round, multiply by conj(a), sum/round
// one transfer per cycle in and out when not stalled
// rate is set by the two 16-way multiplier banks, each fully pipelined
// rst_n (synchronous, active low) clears the stage valid bits only
// each stage holds while the next one is full and stalled, bubbles are squeezed out
`include "quaternion_multiply_rotate_unit_macros.svh"

module quaternion_multiply_rotate_unit
  import qmru_pkg::*;
#(
  parameter int FRAC_BITS  = 14,
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic signed [COMP_WIDTH-1:0] in_a_w,
  input  logic signed [COMP_WIDTH-1:0] in_a_x,
  input  logic signed [COMP_WIDTH-1:0] in_a_y,
  input  logic signed [COMP_WIDTH-1:0] in_a_z,
  input  logic signed [COMP_WIDTH-1:0] in_b_w,
  input  logic signed [COMP_WIDTH-1:0] in_b_x,
  input  logic signed [COMP_WIDTH-1:0] in_b_y,
  input  logic signed [COMP_WIDTH-1:0] in_b_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COMP_WIDTH-1:0] out_r_w,
  output logic signed [COMP_WIDTH-1:0] out_r_x,
  output logic signed [COMP_WIDTH-1:0] out_r_y,
  output logic signed [COMP_WIDTH-1:0] out_r_z,
  output logic                         out_saturated
);

  localparam int PW = 2 * COMP_WIDTH + 1;
  localparam int SW = PW + 2;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [COMP_WIDTH:0]   ext_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [SW-1:0]         sum_t;

  localparam sum_t MAXV = {{(SW-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
  localparam sum_t MINV = {{(SW-COMP_WIDTH+1){1'b1}}, {(COMP_WIDTH-1){1'b0}}};
  localparam sum_t RND  = {{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  function automatic sum_t sx(input prod_t p);
    sx = {{(SW-PW){p[PW-1]}}, p};
  endfunction

  function automatic ext_t ex(input comp_t c);
    ex = {c[COMP_WIDTH-1], c};
  endfunction

  // round half up, then clip to the component range
  function automatic void rnd_sat(input sum_t s, output comp_t v, output logic sat);
    sum_t r;
    r = (s + RND) >>> FRAC_BITS;
    if (r > MAXV) begin
      v   = MAXV[COMP_WIDTH-1:0];
      sat = 1'b1;
    end else if (r < MINV) begin
      v   = MINV[COMP_WIDTH-1:0];
      sat = 1'b1;
    end else begin
      v   = r[COMP_WIDTH-1:0];
      sat = 1'b0;
    end
  endfunction

  // hamilton sums over the product grid, index is a_i * b_j at i*4+j
  function automatic void ham_round(input prod_t p [NUM_PROD], output comp_t r [NUM_COMP],
                                    output logic [NUM_COMP-1:0] sat);
    sum_t s [NUM_COMP];
    s[0] = sx(p[0]) - sx(p[5])  - sx(p[10]) - sx(p[15]);
    s[1] = sx(p[1]) + sx(p[4])  + sx(p[11]) - sx(p[14]);
    s[2] = sx(p[2]) - sx(p[7])  + sx(p[8])  + sx(p[13]);
    s[3] = sx(p[3]) + sx(p[6])  - sx(p[9])  + sx(p[12]);
    for (int k = 0; k < NUM_COMP; k++) begin
      rnd_sat(s[k], r[k], sat[k]);
    end
  endfunction

  // stage enables, each stage advances when empty or when the next one moves
  logic en1, en2, en3, en4;

  logic     s1_v_r, s2_v_r, s3_v_r, out_v_r;
  qmru_op_t s1_op_r, s2_op_r, s3_op_r, out_op_r;
  prod_t    s1_p_r [NUM_PROD];
  prod_t    s3_p_r [NUM_PROD];
  comp_t    s1_a_r [NUM_COMP];
  comp_t    s2_a_r [NUM_COMP];
  comp_t    s2_t_r [NUM_COMP];
  comp_t    s3_t_r [NUM_COMP];
  logic     s2_sat_r, s3_sat_r, out_sat_r;
  comp_t    res_r  [NUM_COMP];

  comp_t    in_a   [NUM_COMP];
  ext_t     in_bx  [NUM_COMP];
  prod_t    p1_nxt [NUM_PROD];
  ext_t     ca     [NUM_COMP];
  prod_t    p3_nxt [NUM_PROD];
  comp_t    t_nxt  [NUM_COMP];
  logic [NUM_COMP-1:0] t_sat;
  comp_t    q_nxt  [NUM_COMP];
  logic [NUM_COMP-1:0] q_sat;
  comp_t    res_nxt [NUM_COMP];
  logic     sat_nxt;

  assign en4      = !out_v_r || out_ready;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  // first product, the scalar of b is dropped for a rotation
  always_comb begin
    in_a[0]  = in_a_w;
    in_a[1]  = in_a_x;
    in_a[2]  = in_a_y;
    in_a[3]  = in_a_z;
    in_bx[0] = (qmru_op_t'(in_opcode) == OP_ROT) ? '0 : ex(in_b_w);
    in_bx[1] = ex(in_b_x);
    in_bx[2] = ex(in_b_y);
    in_bx[3] = ex(in_b_z);
    for (int i = 0; i < NUM_COMP; i++) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        p1_nxt[i*NUM_COMP+j] = prod_t'(in_a[i]) * prod_t'(in_bx[j]);
      end
    end
  end

  always_comb begin
    ham_round(s1_p_r, t_nxt, t_sat);
  end

  // second product against conj(a), formed one bit wider so negation is exact
  always_comb begin
    ca[0] = ex(s2_a_r[0]);
    for (int k = 1; k < NUM_COMP; k++) begin
      ca[k] = -ex(s2_a_r[k]);
    end
    for (int i = 0; i < NUM_COMP; i++) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        p3_nxt[i*NUM_COMP+j] = prod_t'(s2_t_r[i]) * prod_t'(ca[j]);
      end
    end
  end

  always_comb begin
    ham_round(s3_p_r, q_nxt, q_sat);
    if (s3_op_r == OP_ROT) begin
      res_nxt[0] = '0;
      for (int k = 1; k < NUM_COMP; k++) begin
        res_nxt[k] = q_nxt[k];
      end
      sat_nxt = s3_sat_r || (|q_sat[NUM_COMP-1:1]);
    end else begin
      for (int k = 0; k < NUM_COMP; k++) begin
        res_nxt[k] = s3_t_r[k];
      end
      sat_nxt = s3_sat_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r  <= in_valid;
      if (en2) s2_v_r  <= s1_v_r;
      if (en3) s3_v_r  <= s2_v_r;
      if (en4) out_v_r <= s3_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_op_r <= qmru_op_t'(in_opcode);
      s1_p_r  <= p1_nxt;
      s1_a_r  <= in_a;
    end
    if (en2 && s1_v_r) begin
      s2_op_r  <= s1_op_r;
      s2_a_r   <= s1_a_r;
      s2_t_r   <= t_nxt;
      s2_sat_r <= |t_sat;
    end
    if (en3 && s2_v_r) begin
      s3_op_r  <= s2_op_r;
      s3_p_r   <= p3_nxt;
      s3_t_r   <= s2_t_r;
      s3_sat_r <= s2_sat_r;
    end
    if (en4 && s3_v_r) begin
      out_op_r  <= s3_op_r;
      res_r     <= res_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_r_w       = res_r[0];
  assign out_r_x       = res_r[1];
  assign out_r_y       = res_r[2];
  assign out_r_z       = res_r[3];
  assign out_saturated = out_sat_r;

  `QMRU_ASSERT_NEXT(a_take_fills_s1, in_valid && in_ready, s1_v_r, "accepted transfer not captured")
  `QMRU_ASSERT_NEXT(a_s3_holds, s3_v_r && !en4, s3_v_r && $stable(s3_op_r), "stalled item lost")
  `QMRU_ASSERT_SAME(a_rot_scalar, out_v_r && out_op_r == OP_ROT, res_r[0] == '0, "rotation scalar")

endmodule
